// File: src/scbs_pkg.sv
package scbs_pkg;

    // Random bits that one station draws from.
    localparam int RND_BITS = 9;
    // Width of the random input word.
    localparam int RND_W = 36;
    // Width of a station's wait counter.
    localparam int WAIT_W = 10;
    // Width of a station's collision counter.
    localparam int CNT_W = 4;
    // Stations that show in the result masks.
    localparam int MASK_W = 4;
    localparam int TICK_W = 16;
    localparam int STCNT_W = 3;
    localparam int LIMIT_W = 4;
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    // Saturated count of firing stations; two or more means a collision.
    localparam logic [1:0] FIRE_NONE = 2'd0;
    localparam logic [1:0] FIRE_MANY = 2'd2;

    localparam logic [STCNT_W-1:0] STCNT_RESET = 3'd4;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd9;

    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } t_opcode;

    typedef enum logic {
        REG_STATION_COUNT = 1'b0,
        REG_GIVE_UP_LIMIT = 1'b1
    } t_reg_index;

    // Passed combinationally from one station cell to the next.
    typedef struct packed {
        logic [1:0] fire_cnt;
        logic       busy;
    } t_chain;

    // Mask of (2^cnt)-1, capped at all random bits.
    function automatic logic [RND_BITS-1:0] wait_mask(input logic [CNT_W:0] cnt);
        logic [RND_BITS-1:0] m;
        for (int k = 0; k < RND_BITS; k++) begin
            m[k] = (cnt > (CNT_W+1)'(k));
        end
        return m;
    endfunction

endpackage

// File: src/scbs_cell.sv
module scbs_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  scbs_pkg::t_opcode                 i_opcode,
    input  logic                              i_enable,
    input  logic [scbs_pkg::RND_BITS-1:0]     i_rnd,
    input  logic [scbs_pkg::LIMIT_W-1:0]      i_limit,
    input  logic                              i_multi,
    input  scbs_pkg::t_chain                  i_chain,
    output scbs_pkg::t_chain                  o_chain,
    output logic                              o_sent,
    output logic                              o_coll,
    output logic                              o_gave
);

    localparam logic [scbs_pkg::RND_BITS-1:0] StartMask =
        scbs_pkg::wait_mask((scbs_pkg::CNT_W+1)'(1));

    logic                              r_trying;
    logic                              n_trying;
    logic [scbs_pkg::CNT_W-1:0]        r_count;
    logic [scbs_pkg::CNT_W-1:0]        n_count;
    logic [scbs_pkg::WAIT_W-1:0]       r_wait;
    logic [scbs_pkg::WAIT_W-1:0]       n_wait;

    logic                              w_fire;
    logic                              w_tick;
    logic [scbs_pkg::CNT_W:0]          w_nc;
    logic                              w_give;
    logic [scbs_pkg::RND_BITS-1:0]     w_mask;

    assign w_fire = r_trying && (r_wait == '0);
    assign w_tick = (i_opcode == scbs_pkg::OP_TICK);
    assign w_nc   = {1'b0, r_count} + (scbs_pkg::CNT_W+1)'(1);
    assign w_give = (w_nc > {1'b0, i_limit}) || w_nc[scbs_pkg::CNT_W];
    assign w_mask = scbs_pkg::wait_mask(w_nc);

    always_comb begin
        o_chain.fire_cnt = i_chain.fire_cnt;
        if (w_fire && (i_chain.fire_cnt != scbs_pkg::FIRE_MANY)) begin
            o_chain.fire_cnt = i_chain.fire_cnt + 2'd1;
        end
        o_chain.busy = i_chain.busy | n_trying;
    end

    assign o_sent = w_tick && w_fire && !i_multi;
    assign o_coll = w_tick && w_fire && i_multi;
    assign o_gave = o_coll && w_give;

    always_comb begin
        n_trying = r_trying;
        n_count  = r_count;
        n_wait   = r_wait;
        if (!w_tick) begin
            n_trying = i_enable;
            n_count  = i_enable ? scbs_pkg::CNT_W'(1) : '0;
            n_wait   = i_enable ? ({1'b0, i_rnd & StartMask} + scbs_pkg::WAIT_W'(1)) : '0;
        end else if (w_fire) begin
            if (!i_multi) begin
                n_trying = 1'b0;
            end else if (w_give) begin
                n_trying = 1'b0;
                n_count  = w_nc[scbs_pkg::CNT_W] ? '1 : w_nc[scbs_pkg::CNT_W-1:0];
            end else begin
                // The new wait is drawn and already counted down for this tick.
                n_count = w_nc[scbs_pkg::CNT_W-1:0];
                n_wait  = {1'b0, i_rnd & w_mask};
            end
        end else if (r_trying) begin
            n_wait = r_wait - scbs_pkg::WAIT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trying <= 1'b0;
            r_count  <= '0;
            r_wait   <= '0;
        end else if (i_accept) begin
            r_trying <= n_trying;
            r_count  <= n_count;
            r_wait   <= n_wait;
        end
    end

endmodule

// File: src/shared_channel_backoff_sim_unit.sv
// Channel   Direction  Handshake               Payload
// in        input      i_in_valid/o_in_stall   i_opcode, i_random_bits
// out       output     o_out_valid/i_out_stall o_sent_mask, o_collision_mask,
//                                              o_gave_up_mask, o_all_done, o_tick_number
// config    input      APB psel/penable/pready paddr, pwdata, prdata
//
// One item per cycle unless the input stalls; each result is registered on acceptance.
// All station cells update in the same cycle, with the firing count rippled along the row.
// A two-entry output buffer (output register plus skid) takes one more item while output
// stalls; input stalls once both entries are full.
// Synchronous active-low reset leaves all stations idle; no clearing pass is needed.
module shared_channel_backoff_sim_unit #(
    parameter int STATIONS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_opcode,
    input  logic [scbs_pkg::RND_W-1:0]          i_random_bits,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [scbs_pkg::MASK_W-1:0]         o_sent_mask,
    output logic [scbs_pkg::MASK_W-1:0]         o_collision_mask,
    output logic [scbs_pkg::MASK_W-1:0]         o_gave_up_mask,
    output logic                                o_all_done,
    output logic [scbs_pkg::TICK_W-1:0]         o_tick_number,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [scbs_pkg::APB_AW-1:0]         paddr,
    input  logic [scbs_pkg::APB_DW-1:0]         pwdata,
    output logic [scbs_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);

    typedef struct packed {
        logic [scbs_pkg::MASK_W-1:0] sent;
        logic [scbs_pkg::MASK_W-1:0] coll;
        logic [scbs_pkg::MASK_W-1:0] gave;
        logic                        done;
        logic [scbs_pkg::TICK_W-1:0] tick;
    } t_result;

    // Configuration registers.
    logic [scbs_pkg::STCNT_W-1:0] r_station_count;
    logic [scbs_pkg::LIMIT_W-1:0] r_give_up_limit;
    logic                         w_cfg_wr;
    scbs_pkg::t_reg_index         w_reg;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_reg    = scbs_pkg::t_reg_index'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_count <= scbs_pkg::STCNT_RESET;
            r_give_up_limit <= scbs_pkg::LIMIT_RESET;
        end else if (w_cfg_wr) begin
            case (w_reg)
                scbs_pkg::REG_STATION_COUNT: r_station_count <= pwdata[scbs_pkg::STCNT_W-1:0];
                scbs_pkg::REG_GIVE_UP_LIMIT: r_give_up_limit <= pwdata[scbs_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            scbs_pkg::REG_STATION_COUNT: prdata = scbs_pkg::APB_DW'(r_station_count);
            scbs_pkg::REG_GIVE_UP_LIMIT: prdata = scbs_pkg::APB_DW'(r_give_up_limit);
            default:                     prdata = '0;
        endcase
    end

    // Handshake and output buffering.
    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    t_result w_res;
    logic    w_accept;
    logic    w_out_free;

    assign o_in_stall = r_skid_valid;
    assign w_accept   = i_in_valid && !r_skid_valid;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid  <= r_skid_valid || w_accept;
            r_skid_valid <= 1'b0;
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (w_accept) begin
            r_skid <= w_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_sent_mask      = r_out.sent;
    assign o_collision_mask = r_out.coll;
    assign o_gave_up_mask   = r_out.gave;
    assign o_all_done       = r_out.done;
    assign o_tick_number    = r_out.tick;

    // Tick counter.
    logic [scbs_pkg::TICK_W-1:0] r_tick;
    scbs_pkg::t_opcode           w_op;

    assign w_op = scbs_pkg::t_opcode'(i_opcode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
        end else if (w_accept) begin
            if (w_op == scbs_pkg::OP_START) begin
                r_tick <= '0;
            end else if (r_tick != '1) begin
                r_tick <= r_tick + scbs_pkg::TICK_W'(1);
            end
        end
    end

    // Row of station cells.
    scbs_pkg::t_chain        w_chain [STATIONS+1];
    logic [STATIONS-1:0]     w_sent;
    logic [STATIONS-1:0]     w_coll;
    logic [STATIONS-1:0]     w_gave;
    logic                    w_multi;

    assign w_chain[0] = '0;
    assign w_multi    = (w_chain[STATIONS].fire_cnt == scbs_pkg::FIRE_MANY);

    for (genvar gi = 0; gi < STATIONS; gi++) begin : g_station
        logic [scbs_pkg::RND_BITS-1:0] w_rnd;
        if (scbs_pkg::RND_BITS*gi + scbs_pkg::RND_BITS <= scbs_pkg::RND_W) begin : g_rnd
            assign w_rnd = i_random_bits[scbs_pkg::RND_BITS*gi +: scbs_pkg::RND_BITS];
        end else begin : g_no_rnd
            assign w_rnd = '0;
        end

        scbs_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_accept (w_accept),
            .i_opcode (w_op),
            .i_enable (scbs_pkg::STCNT_W'(gi) < r_station_count),
            .i_rnd    (w_rnd),
            .i_limit  (r_give_up_limit),
            .i_multi  (w_multi),
            .i_chain  (w_chain[gi]),
            .o_chain  (w_chain[gi+1]),
            .o_sent   (w_sent[gi]),
            .o_coll   (w_coll[gi]),
            .o_gave   (w_gave[gi])
        );
    end

    logic [STATIONS+scbs_pkg::MASK_W-1:0] w_sent_pad;
    logic [STATIONS+scbs_pkg::MASK_W-1:0] w_coll_pad;
    logic [STATIONS+scbs_pkg::MASK_W-1:0] w_gave_pad;

    assign w_sent_pad = {{scbs_pkg::MASK_W{1'b0}}, w_sent};
    assign w_coll_pad = {{scbs_pkg::MASK_W{1'b0}}, w_coll};
    assign w_gave_pad = {{scbs_pkg::MASK_W{1'b0}}, w_gave};

    always_comb begin
        w_res.sent = w_sent_pad[scbs_pkg::MASK_W-1:0];
        w_res.coll = w_coll_pad[scbs_pkg::MASK_W-1:0];
        w_res.gave = w_gave_pad[scbs_pkg::MASK_W-1:0];
        w_res.done = !w_chain[STATIONS].busy;
        w_res.tick = (w_op == scbs_pkg::OP_START) ? '0 : r_tick;
    end

endmodule

// File: src/scbs_checker.sv
module scbs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [3:0]  o_sent_mask,
    input logic [3:0]  o_collision_mask,
    input logic [3:0]  o_gave_up_mask,
    input logic        o_all_done,
    input logic [15:0] o_tick_number
);

    // A held result keeps its valid and its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sent_mask)
            && $stable(o_collision_mask) && $stable(o_gave_up_mask)
            && $stable(o_all_done) && $stable(o_tick_number))
        else $error("result changed while stalled");

    // Input is only held off when a result is already waiting.
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

    // A station that gives up must also have collided, and never also sent.
    a_gave_in_coll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_gave_up_mask & ~o_collision_mask) == 4'd0)
            && ((o_sent_mask & o_collision_mask) == 4'd0))
        else $error("inconsistent station masks");

    // At most one station can send alone in a tick.
    a_single_sender: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $countones(o_sent_mask) <= 1)
        else $error("more than one sender in a tick");

endmodule

bind shared_channel_backoff_sim_unit scbs_checker u_scbs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_sent_mask      (o_sent_mask),
    .o_collision_mask (o_collision_mask),
    .o_gave_up_mask   (o_gave_up_mask),
    .o_all_done       (o_all_done),
    .o_tick_number    (o_tick_number)
);
